// ===== rtl/set_associative_cache_assert.svh =====
// Assertion macros shared by the cache modules.
`ifndef SET_ASSOCIATIVE_CACHE_ASSERT_SVH
`define SET_ASSOCIATIVE_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define SAC_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Implication checked in the next cycle.
`define SAC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define SAC_ASSERT_IMP(lbl, a, b)
`define SAC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== rtl/sac_pkg.sv =====
// Shared constants, payload types and control structs of the cache.
package sac_pkg;
  localparam int SET_BITS   = 6;
  localparam int WAY_BITS   = 2;
  localparam int BLOCK_BITS = 6;
  localparam int WORD_BITS  = BLOCK_BITS - 2;
  localparam int WAYS       = 1 << WAY_BITS;
  localparam int SETS       = 1 << SET_BITS;
  localparam int TAG_W      = 32 - SET_BITS - BLOCK_BITS;
  localparam int LINE_W     = SET_BITS + WAY_BITS;
  localparam int LINES      = 1 << LINE_W;
  localparam int DIDX_W     = LINE_W + WORD_BITS;
  localparam int DWORDS     = 1 << DIDX_W;
  localparam int PAD_W      = 32 - TAG_W - SET_BITS - WORD_BITS;
  localparam logic [15:0] LFSR_POLY = 16'hB400;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WDONE = 3'd1;
  localparam logic [2:0] KIND_MEMW  = 3'd2;
  localparam logic [2:0] KIND_REQ   = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic CFG_WB_MODE = 1'b0;
  localparam logic CFG_SEED    = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] wmask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic [31:0] rdata;
    logic [31:0] mem_addr;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    DA_ACC  = 2'd0,
    DA_EV   = 2'd1,
    DA_FILL = 2'd2
  } dsel_t;

  typedef struct packed {
    logic       lat_acc;
    logic       lat_fill;
    logic       take_hit;
    logic       miss;
    dsel_t      dsel;
    logic       drd;
    logic       dwr_merge;
    logic       dwr_fill;
    logic       set_dirty;
    logic       fill_step;
    logic       fill_done;
    logic       ev_step;
    logic       miss_commit;
    logic       emit;
    logic       ev_emit;
    logic [2:0] kind;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic       evict;
    logic       pend;
    logic       fill_last;
    logic       ev_last;
    logic       wb;
    logic [1:0] op;
  } stat_t;
endpackage

// ===== rtl/sac_datapath.sv =====
// Datapath: tag and data memories, valid and dirty bits, LFSR and result register.
module sac_datapath import sac_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  in_item_t     item,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  cmd_t         cmd,
  output stat_t        st,
  output logic         result_valid,
  output out_item_t    result
);
  logic [1:0]          acc_op;
  logic [31:0]         acc_addr, acc_wdata, acc_wmask, fill_word;
  logic [LINE_W-1:0]   acc_line;
  logic                acc_hit, pend, wb, evict;
  logic [WORD_BITS-1:0] fill_cnt, ev_cnt;
  logic [TAG_W-1:0]    vic_tag;
  logic [15:0]         lfsr, lfsr_step;
  logic [LINES-1:0]    valid, dirty;
  logic [TAG_W-1:0]    tag_mem [WAYS][SETS];
  logic [TAG_W-1:0]    tag_q [WAYS];
  logic [31:0]         dmem [DWORDS];
  logic [31:0]         dq, merged, dwd;
  logic [DIDX_W-1:0]   da;
  logic                dwe;
  logic [SET_BITS-1:0] acc_set, in_set;
  logic [TAG_W-1:0]    acc_tag;
  logic [WAY_BITS-1:0] hit_way, vic_way, inv_way;
  logic                any_hit, any_inv;
  out_item_t           res_next;

  assign acc_set = acc_addr[BLOCK_BITS +: SET_BITS];
  assign acc_tag = acc_addr[31 -: TAG_W];
  assign in_set  = item.addr[BLOCK_BITS +: SET_BITS];

  // Galois LFSR step.
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_POLY) : (lfsr >> 1);

  // Tag compare and victim choice over the ways of the set.
  always_comb begin
    any_hit = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[{acc_set, WAY_BITS'(w)}] && tag_q[w] == acc_tag) begin
        any_hit = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!valid[{acc_set, WAY_BITS'(w)}]) begin
        any_inv = 1'b1;
        inv_way = WAY_BITS'(w);
      end
    end
    vic_way = any_inv ? inv_way : lfsr_step[WAY_BITS-1:0];
  end

  assign st.hit       = any_hit;
  assign st.evict     = !any_inv && wb && dirty[{acc_set, vic_way}];
  assign st.pend      = pend;
  assign st.fill_last = &fill_cnt;
  assign st.ev_last   = &ev_cnt;
  assign st.wb        = wb;
  assign st.op        = acc_op;

  // Tag memory, one array per way, read at the incoming set every cycle.
  always_ff @(posedge clk) begin
    for (int w = 0; w < WAYS; w++) begin
      if (cmd.fill_done && acc_line[WAY_BITS-1:0] == WAY_BITS'(w)) begin
        tag_mem[w][acc_set] <= acc_tag;
      end
      tag_q[w] <= tag_mem[w][in_set];
    end
  end

  // Data memory with one address and registered read data.
  assign merged = (dq & ~acc_wmask) | (acc_wdata & acc_wmask);
  always_comb begin
    unique case (cmd.dsel)
      DA_EV:   da = {acc_line, ev_cnt};
      DA_FILL: da = {acc_line, fill_cnt};
      default: da = {acc_line, acc_addr[2 +: WORD_BITS]};
    endcase
  end
  assign dwe = cmd.dwr_merge || cmd.dwr_fill;
  assign dwd = cmd.dwr_fill ? fill_word : merged;
  always_ff @(posedge clk) begin
    if (dwe) begin
      dmem[da] <= dwd;
    end
    if (cmd.drd) begin
      dq <= dmem[da];
    end
  end

  // Access, pending-miss, counter, valid, dirty, mode and LFSR registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      fill_cnt <= '0;
      ev_cnt   <= '0;
      valid    <= '0;
      dirty    <= '0;
      wb       <= 1'b1;
      lfsr     <= 16'd1;
      acc_hit  <= 1'b0;
      evict    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_WB_MODE) begin
        wb <= cfg_data[0];
      end
      if (cfg_we && cfg_index == CFG_SEED) begin
        lfsr <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
      end
      if (cmd.take_hit) begin
        acc_line <= {acc_set, hit_way};
        acc_hit  <= 1'b1;
      end
      if (cmd.miss) begin
        acc_line <= {acc_set, vic_way};
        acc_hit  <= 1'b0;
        vic_tag  <= tag_q[vic_way];
        evict    <= st.evict;
        ev_cnt   <= '0;
        if (!any_inv) begin
          lfsr <= lfsr_step;
        end
      end
      if (cmd.ev_step) begin
        ev_cnt <= ev_cnt + 1'b1;
      end
      if (cmd.miss_commit) begin
        valid[acc_line] <= 1'b0;
        dirty[acc_line] <= 1'b0;
        pend            <= 1'b1;
        fill_cnt        <= '0;
      end
      if (cmd.fill_step) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (cmd.fill_done) begin
        valid[acc_line] <= 1'b1;
        dirty[acc_line] <= 1'b0;
        pend            <= 1'b0;
      end
      if (cmd.set_dirty) begin
        dirty[acc_line] <= 1'b1;
      end
    end
  end

  // Input latches for the access and the fill word.
  always_ff @(posedge clk) begin
    if (cmd.lat_acc) begin
      acc_op    <= item.op;
      acc_addr  <= item.addr;
      acc_wdata <= item.wdata;
      acc_wmask <= item.wmask;
    end
    if (cmd.lat_fill) begin
      fill_word <= item.wdata;
    end
  end

  // Result payload by kind.
  always_comb begin
    res_next.kind     = cmd.kind;
    res_next.last     = cmd.last;
    res_next.hit      = 1'b0;
    res_next.rdata    = '0;
    res_next.mem_addr = '0;
    unique case (cmd.kind)
      KIND_READ: begin
        res_next.hit   = acc_hit;
        res_next.rdata = dq;
      end
      KIND_WDONE: begin
        res_next.hit = acc_hit;
      end
      KIND_MEMW: begin
        if (cmd.ev_emit) begin
          res_next.rdata    = dq;
          res_next.mem_addr = {{PAD_W{1'b0}}, vic_tag, acc_set, ev_cnt};
        end else begin
          res_next.hit      = acc_hit;
          res_next.rdata    = merged;
          res_next.mem_addr = {2'b00, acc_addr[31:2]};
        end
      end
      KIND_REQ: begin
        res_next.mem_addr = {{BLOCK_BITS{1'b0}}, acc_addr[31:BLOCK_BITS]};
      end
      default: begin
      end
    endcase
  end

  // Result register: each result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      result <= res_next;
    end
  end

  `include "set_associative_cache_assert.svh"
  `SAC_ASSERT_NEXT(a_commit_pend, cmd.miss_commit, pend)
  `SAC_ASSERT_NEXT(a_fill_clears, cmd.fill_done, !pend && valid[acc_line])
  `SAC_ASSERT_IMP(a_evict_wb, cmd.ev_emit, evict)
endmodule

// ===== rtl/sac_ctrl.sv =====
// Controller state machine that sequences lookups, evictions and fills.
module sac_ctrl import sac_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic [1:0] in_op,
  input  stat_t    st,
  output logic     busy,
  output cmd_t     cmd
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_ERR   = 11'b000_0000_0010,
    S_TAG   = 11'b000_0000_0100,
    S_DRD   = 11'b000_0000_1000,
    S_ACC   = 11'b000_0001_0000,
    S_WDONE = 11'b000_0010_0000,
    S_EVRD  = 11'b000_0100_0000,
    S_EVOUT = 11'b000_1000_0000,
    S_REQ   = 11'b001_0000_0000,
    S_FILL  = 11'b010_0000_0000,
    S_FDONE = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   accept, bad;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign bad    = (in_op != OP_READ && in_op != OP_WRITE && in_op != OP_FILL) ||
                  (in_op == OP_FILL && !st.pend) || (in_op != OP_FILL && st.pend);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.dsel   = DA_ACC;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (bad) begin
            state_next = S_ERR;
          end else if (in_op == OP_FILL) begin
            cmd.lat_fill = 1'b1;
            state_next   = S_FILL;
          end else begin
            cmd.lat_acc = 1'b1;
            state_next  = S_TAG;
          end
        end
      end
      S_ERR: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_ERR;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_TAG: begin
        if (st.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_DRD;
        end else begin
          cmd.miss   = 1'b1;
          state_next = st.evict ? S_EVRD : S_REQ;
        end
      end
      S_DRD: begin
        cmd.drd    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.emit = 1'b1;
        if (st.op == OP_READ) begin
          cmd.kind   = KIND_READ;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.dwr_merge = 1'b1;
          if (st.wb) begin
            cmd.set_dirty = 1'b1;
            cmd.kind      = KIND_WDONE;
            cmd.last      = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.kind   = KIND_MEMW;
            state_next = S_WDONE;
          end
        end
      end
      S_WDONE: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_WDONE;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_EVRD: begin
        cmd.dsel   = DA_EV;
        cmd.drd    = 1'b1;
        state_next = S_EVOUT;
      end
      S_EVOUT: begin
        cmd.emit    = 1'b1;
        cmd.ev_emit = 1'b1;
        cmd.kind    = KIND_MEMW;
        cmd.ev_step = 1'b1;
        state_next  = st.ev_last ? S_REQ : S_EVRD;
      end
      S_REQ: begin
        cmd.emit        = 1'b1;
        cmd.kind        = KIND_REQ;
        cmd.last        = 1'b1;
        cmd.miss_commit = 1'b1;
        state_next      = S_IDLE;
      end
      S_FILL: begin
        cmd.dsel      = DA_FILL;
        cmd.dwr_fill  = 1'b1;
        cmd.fill_step = 1'b1;
        state_next    = st.fill_last ? S_FDONE : S_IDLE;
      end
      S_FDONE: begin
        cmd.fill_done = 1'b1;
        cmd.drd       = 1'b1;
        state_next    = S_ACC;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `include "set_associative_cache_assert.svh"
  `SAC_ASSERT_NEXT(a_accept_busy, accept, busy)
  `SAC_ASSERT_NEXT(a_evict_to_req, state == S_EVOUT && st.ev_last, state == S_REQ)
  `SAC_ASSERT_IMP(a_emit_busy, cmd.emit, busy)
endmodule

// ===== rtl/set_associative_cache.sv =====
// Set-associative cache, 4 ways x 64 sets x 16 words, random replacement.
// A hit passes tag lookup, data read and access; write-through adds a write-done.
// A miss reads and emits each dirty victim word in turn, then the block request.
// Each fill word is written in its own pass; the last one also completes the access.
// One item at a time; results are strobed for one cycle and cannot be stalled.
// Synchronous reset: all lines invalid and clean, LFSR 1, write-back mode.
module set_associative_cache import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  output logic        result_valid,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  sac_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .in_op (item.op),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  sac_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result       (result)
  );
endmodule

// ===== test/tb_set_associative_cache.sv =====
// Self-checking testbench of the set-associative cache with random replacement.
module tb_set_associative_cache;
  import sac_pkg::*;

  // Scoreboard: mirrors the cache state and queues the results each transfer should cause.
  class cache_scoreboard;
    logic [TAG_W-1:0] tags [LINES];
    bit               valid [LINES];
    bit               dirty [LINES];
    logic [31:0]      words [DWORDS];
    bit               wb_mode;
    logic [15:0]      lfsr;
    bit               miss_open;
    in_item_t         miss_item;
    int               miss_line;
    int               fill_idx;
    out_item_t        due [$];
    int               errors;

    function new();
      for (int i = 0; i < LINES; i++) begin
        valid[i] = 0;
        dirty[i] = 0;
      end
      wb_mode = 1;
      lfsr = 16'd1;
      miss_open = 0;
      fill_idx = 0;
      errors = 0;
    endfunction

    function void add(logic [2:0] kind, logic hit, logic [31:0] rd, logic [31:0] ma);
      out_item_t r;
      r.kind = kind;
      r.hit = hit;
      r.rdata = rd;
      r.mem_addr = ma;
      r.last = 0;
      due.push_back(r);
    endfunction

    function void set_cfg(logic idx, logic [31:0] data);
      if (idx == CFG_WB_MODE) begin
        wb_mode = data[0];
      end else begin
        lfsr = (data[15:0] == 16'd0) ? 16'd1 : data[15:0];
      end
    endfunction

    // Completes a read or write on a line that now holds the block.
    function void complete(in_item_t it, int line, logic hit);
      int di;
      di = line * 16 + it.addr[5:2];
      if (it.op == OP_READ) begin
        add(KIND_READ, hit, words[di], 32'd0);
        return;
      end
      words[di] = (words[di] & ~it.wmask) | (it.wdata & it.wmask);
      if (wb_mode) begin
        dirty[line] = 1;
      end else begin
        add(KIND_MEMW, hit, words[di], {2'b00, it.addr[31:2]});
      end
      add(KIND_WDONE, hit, 32'd0, 32'd0);
    endfunction

    function void note_input(in_item_t it);
      int n0;
      int base;
      int line;
      bit found;
      logic [5:0] set;
      logic [TAG_W-1:0] tag;
      logic [31:0] blk;
      n0 = due.size();
      set = it.addr[11:6];
      tag = it.addr[31:12];
      base = set * WAYS;
      if (it.op == 2'd3 || (it.op == OP_FILL) != miss_open) begin
        add(KIND_ERR, 0, 32'd0, 32'd0);
      end else if (it.op == OP_FILL) begin
        words[miss_line * 16 + fill_idx] = it.wdata;
        if (fill_idx != 15) begin
          fill_idx++;
        end else begin
          fill_idx = 0;
          miss_open = 0;
          tags[miss_line] = miss_item.addr[31:12];
          valid[miss_line] = 1;
          dirty[miss_line] = 0;
          complete(miss_item, miss_line, 0);
        end
      end else begin
        found = 0;
        for (int w = 0; w < WAYS; w++) begin
          if (!found && valid[base + w] && tags[base + w] == tag) begin
            complete(it, base + w, 1);
            found = 1;
          end
        end
        if (!found) begin
          line = -1;
          for (int w = 0; w < WAYS; w++) begin
            if (line < 0 && !valid[base + w]) line = base + w;
          end
          if (line < 0) begin
            // All ways valid: step the LFSR and evict the way it picks.
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_POLY) : (lfsr >> 1);
            line = base + lfsr[1:0];
            if (wb_mode && dirty[line]) begin
              blk = {tags[line], set};
              for (int i = 0; i < 16; i++) begin
                add(KIND_MEMW, 0, words[line * 16 + i], (blk << 4) | i);
              end
            end
          end
          add(KIND_REQ, 0, 32'd0, it.addr >> 6);
          valid[line] = 0;
          dirty[line] = 0;
          miss_open = 1;
          miss_item = it;
          miss_line = line;
          fill_idx = 0;
        end
      end
      if (due.size() > n0) due[due.size() - 1].last = 1;
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.hit !== want.hit || got.rdata !== want.rdata ||
          got.mem_addr !== want.mem_addr || got.last !== want.last) begin
        $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    item;
  logic        result_valid;
  out_item_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  cache_scoreboard sb;
  int idle_cycles;
  int sent;

  set_associative_cache i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result checking and a watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check(result);
      if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= 3000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drives one transfer and leaves start high; idle() with a nonzero count lowers it.
  task automatic send(in_item_t it);
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    sent++;
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic put_item(logic [1:0] op, logic [31:0] a, logic [31:0] d, logic [31:0] m);
    in_item_t it;
    it.op = op;
    it.addr = a;
    it.wdata = d;
    it.wmask = m;
    send(it);
    idle(gap_len());
  endtask

  // Streams the sixteen fill words of an open miss.
  task automatic fill_block();
    while (sb.miss_open) begin
      put_item(OP_FILL, $urandom(), $urandom(), $urandom());
    end
  endtask

  // Access followed by its fills; sometimes a stray access or bad op lands mid-miss.
  task automatic access(logic [1:0] op, logic [31:0] a, logic [31:0] d, logic [31:0] m);
    put_item(op, a, d, m);
    if (sb.miss_open && $urandom_range(0, 7) == 0) begin
      put_item($urandom_range(0, 1) ? 2'd3 : OP_READ, $urandom(), $urandom(), $urandom());
    end
    fill_block();
  endtask

  // Waits until nothing is expected, then lets a miss-free block settle.
  task automatic drain();
    idle(1);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_cfg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_addr();
    logic [19:0] tag;
    logic [5:0]  set;
    if ($urandom_range(0, 9) == 0) return $urandom();
    case ($urandom_range(0, 3))
      0: tag = 20'hFFFFF;
      default: tag = 20'($urandom_range(0, 6));
    endcase
    case ($urandom_range(0, 3))
      0: set = 6'd0;
      1: set = 6'd63;
      default: set = 6'($urandom_range(0, 3));
    endcase
    return {tag, set, 4'($urandom()), 2'($urandom())};
  endfunction

  task automatic random_phase(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        access($urandom_range(0, 1) ? OP_WRITE : OP_READ, pick_addr(), $urandom(),
               $urandom_range(0, 3) == 0 ? 32'hFFFFFFFF : $urandom());
      end else if (r < 90) begin
        put_item(2'd3, $urandom(), $urandom(), $urandom());
      end else begin
        put_item(OP_FILL, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WB_MODE;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: misses, hits, mask extremes, errors, dirty eviction, mode switch.
    put_item(OP_FILL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    put_item(2'd3, 32'd0, 32'd0, 32'd0);
    access(OP_READ, 32'h0000_0000, 32'd0, 32'd0);
    put_item(OP_READ, 32'h0000_003F, 32'd0, 32'd0);
    put_item(OP_WRITE, 32'h0000_0004, 32'hFFFFFFFF, 32'hFFFFFFFF);
    put_item(OP_WRITE, 32'h0000_0008, 32'hFFFFFFFF, 32'h0);
    put_item(OP_WRITE, 32'hFFFF_FFFF, 32'hA5A5A5A5, 32'h0F0F0F0F);
    put_item(OP_READ, 32'h1234_5000, 32'd0, 32'd0);
    put_item(OP_WRITE, 32'h0000_0000, 32'd1, 32'd1);
    fill_block();
    for (int t = 1; t <= 5; t++) begin
      access(OP_WRITE, {20'(t), 6'd0, 6'd0}, $urandom(), 32'hFFFFFFFF);
    end
    write_cfg(CFG_WB_MODE, 32'd0);
    for (int t = 6; t <= 9; t++) begin
      access(OP_WRITE, {20'(t), 6'd0, 6'd4}, $urandom(), $urandom());
    end
    write_cfg(CFG_SEED, 32'd0);
    while (sent < 260) random_phase(1);
    write_cfg(CFG_SEED, 32'h0000FFFF);
    write_cfg(CFG_WB_MODE, 32'd1);
    while (sent < 330) random_phase(1);
    write_cfg(CFG_SEED, $urandom());
    while (sent < 390) random_phase(1);
    write_cfg(CFG_WB_MODE, 32'hFFFFFFFE);
    write_cfg(CFG_SEED, 32'h00010001);
    while (sent < 440) random_phase(1);
    write_cfg(CFG_WB_MODE, 32'hFFFFFFFF);
    while (sent < 470) random_phase(1);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.due.size() != 0) begin
        $display("%0t: %0d expected results never arrived, expected %p, actual none",
                 $time, sb.due.size(), sb.due[0]);
      end
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== set_associative_cache.f =====
+incdir+rtl
rtl/sac_pkg.sv
rtl/sac_datapath.sv
rtl/sac_ctrl.sv
rtl/set_associative_cache.sv
test/tb_set_associative_cache.sv
